// ===== rtl/qacs_pkg.sv =====
// shared constants, types and helper functions for the quote-aware command splitter
package qacs_pkg;

    localparam int LINE_MAX = 256;
    localparam int POS_W    = 9;
    localparam int LEN_W    = 8;
    localparam int LIM_W    = 9;
    localparam int CFG_W    = 9;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_SPLIT_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_LIMIT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_RIGHT_LIMIT = 2'd2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(LINE_MAX);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic             found;
        logic             append;
        logic [POS_W-1:0] left_start;
        logic [LEN_W-1:0] left_len;
        logic [POS_W-1:0] right_start;
        logic [LEN_W-1:0] right_len;
        logic             ok;
        logic             too_long;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [LEN_W-1:0] clip_len(input logic [POS_W-1:0] len,
                                                  input logic [LIM_W-1:0] limit);
        logic [LIM_W-1:0] cap;
        cap = (limit == '0) ? '0 : limit - LIM_W'(1);
        if (cap > LIM_W'(255))
        begin
            cap = LIM_W'(255);
        end
        return (LIM_W'(len) < cap) ? LEN_W'(len) : LEN_W'(cap);
    endfunction

endpackage

// ===== rtl/quote_aware_command_splitter_core.sv =====
// quote-aware command splitter: top level with scanner state, result register and skid stage
//
// usage
//   characters arrive on the char channel (char_valid, char_stall, char_code), one per
//   transfer; a zero character ends the line. every other character gives no result.
//   each zero character gives one result transfer on the result channel (result_valid,
//   result_stall and the result fields), taken from the result register. throughput is
//   one character per cycle while char_stall is low; the quote, escape and delimiter
//   flags and the segment indices are updated in the cycle of the transfer, and the trim
//   and clip of the line end go into the result register, or the skid stage on a stall.
//   the user writes the registers split_mode, left_limit and right_limit through cfg_we,
//   cfg_index and cfg_data only while the block is idle; the block does not enforce this.
//   reset clears the line state, empties the result register and the skid stage and
//   sets split_mode 0 and both limits 256.
//   while the receiver stalls, the result is held; one more result goes into the skid
//   stage and char_stall rises only once that stage is full, so characters keep
//   flowing while a single result waits.
module quote_aware_command_splitter_core
    import qacs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             char_valid,
    output logic             char_stall,
    input  logic [7:0]       char_code,
    output logic             result_valid,
    input  logic             result_stall,
    output logic             found,
    output logic             append,
    output logic [POS_W-1:0] left_start,
    output logic [LEN_W-1:0] left_len,
    output logic [POS_W-1:0] right_start,
    output logic [LEN_W-1:0] right_len,
    output logic             ok,
    output logic             too_long
);

    logic             split_mode_reg;
    logic [LIM_W-1:0] left_limit_reg;
    logic [LIM_W-1:0] right_limit_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             sq_reg, sq_next;
    logic             dq_reg, dq_next;
    logic             esc_reg, esc_next;
    logic             delim_reg, delim_next;
    logic [POS_W-1:0] delim_pos_reg, delim_pos_next;
    logic             chk_gt_reg, chk_gt_next;
    logic             app_reg, app_next;
    logic             left_any_reg, left_any_next;
    logic [POS_W-1:0] left_first_reg, left_first_next;
    logic [POS_W-1:0] left_end_reg, left_end_next;
    logic             right_any_reg, right_any_next;
    logic [POS_W-1:0] right_first_reg, right_first_next;
    logic [POS_W-1:0] right_end_reg, right_end_next;
    logic             ovf_reg, ovf_next;

    result_t          out_reg;
    result_t          skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic             char_take;
    logic             line_end;
    logic             out_free;
    logic [7:0]       target;
    logic [POS_W-1:0] left_span;
    logic [POS_W-1:0] right_span;
    result_t          res;

    assign char_stall = skid_valid_reg;
    assign char_take  = char_valid && !char_stall;
    assign line_end   = char_take && (char_code == CH_NUL);
    assign out_free   = !out_valid_reg || !result_stall;
    assign target     = split_mode_reg ? CH_PIPE : CH_GT;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_reg  <= 1'b0;
            left_limit_reg  <= LIMIT_RESET;
            right_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPLIT_MODE:  split_mode_reg  <= cfg_data[0];
                REG_LEFT_LIMIT:  left_limit_reg  <= cfg_data;
                REG_RIGHT_LIMIT: right_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // result at line end
    always_comb
    begin
        left_span  = left_any_reg ? (left_end_reg - left_first_reg) : '0;
        right_span = right_any_reg ? (right_end_reg - right_first_reg) : '0;
        res = '0;
        res.too_long = ovf_reg;
        if (delim_reg)
        begin
            res.found       = 1'b1;
            res.append      = app_reg;
            res.left_start  = left_any_reg ? left_first_reg : delim_pos_reg;
            res.left_len    = clip_len(left_span, left_limit_reg);
            res.right_start = right_any_reg ? right_first_reg : pos_reg;
            res.right_len   = clip_len(right_span, right_limit_reg);
            res.ok          = (res.left_len != '0) && (res.right_len != '0);
        end
    end

    // scanner next state
    always_comb
    begin
        pos_next         = pos_reg;
        sq_next          = sq_reg;
        dq_next          = dq_reg;
        esc_next         = esc_reg;
        delim_next       = delim_reg;
        delim_pos_next   = delim_pos_reg;
        chk_gt_next      = chk_gt_reg;
        app_next         = app_reg;
        left_any_next    = left_any_reg;
        left_first_next  = left_first_reg;
        left_end_next    = left_end_reg;
        right_any_next   = right_any_reg;
        right_first_next = right_first_reg;
        right_end_next   = right_end_reg;
        ovf_next         = ovf_reg;

        if (line_end)
        begin
            pos_next       = '0;
            sq_next        = 1'b0;
            dq_next        = 1'b0;
            esc_next       = 1'b0;
            delim_next     = 1'b0;
            delim_pos_next = '0;
            chk_gt_next    = 1'b0;
            app_next       = 1'b0;
            left_any_next  = 1'b0;
            left_first_next = '0;
            left_end_next  = '0;
            right_any_next = 1'b0;
            right_first_next = '0;
            right_end_next = '0;
            ovf_next       = 1'b0;
        end
        else if (char_take)
        begin
            if (pos_reg >= POS_LIMIT)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (!delim_reg)
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (char_code == CH_BSLASH && !sq_reg)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (char_code == CH_SQUOTE && !dq_reg)
                    begin
                        sq_next = !sq_reg;
                    end
                    else if (char_code == CH_DQUOTE && !sq_reg)
                    begin
                        dq_next = !dq_reg;
                    end
                    else if (char_code == target && !sq_reg && !dq_reg)
                    begin
                        delim_next     = 1'b1;
                        delim_pos_next = pos_reg;
                        chk_gt_next    = !split_mode_reg;
                    end
                    // delimiter itself is in neither segment
                    if (!delim_next && !is_blank(char_code))
                    begin
                        if (!left_any_reg)
                        begin
                            left_any_next   = 1'b1;
                            left_first_next = pos_reg;
                        end
                        left_end_next = pos_reg + POS_W'(1);
                    end
                end
                else if (chk_gt_reg && char_code == CH_GT)
                begin
                    chk_gt_next = 1'b0;
                    app_next    = 1'b1;
                end
                else
                begin
                    chk_gt_next = 1'b0;
                    if (!is_blank(char_code))
                    begin
                        if (!right_any_reg)
                        begin
                            right_any_next   = 1'b1;
                            right_first_next = pos_reg;
                        end
                        right_end_next = pos_reg + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            sq_reg          <= 1'b0;
            dq_reg          <= 1'b0;
            esc_reg         <= 1'b0;
            delim_reg       <= 1'b0;
            delim_pos_reg   <= '0;
            chk_gt_reg      <= 1'b0;
            app_reg         <= 1'b0;
            left_any_reg    <= 1'b0;
            left_first_reg  <= '0;
            left_end_reg    <= '0;
            right_any_reg   <= 1'b0;
            right_first_reg <= '0;
            right_end_reg   <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            sq_reg          <= sq_next;
            dq_reg          <= dq_next;
            esc_reg         <= esc_next;
            delim_reg       <= delim_next;
            delim_pos_reg   <= delim_pos_next;
            chk_gt_reg      <= chk_gt_next;
            app_reg         <= app_next;
            left_any_reg    <= left_any_next;
            left_first_reg  <= left_first_next;
            left_end_reg    <= left_end_next;
            right_any_reg   <= right_any_next;
            right_first_reg <= right_first_next;
            right_end_reg   <= right_end_next;
            ovf_reg         <= ovf_next;
        end
    end

    // result register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= line_end;
            end
        end
        else if (line_end)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (line_end)
            begin
                out_reg <= res;
            end
        end
        else if (line_end)
        begin
            skid_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = out_reg.found;
    assign append       = out_reg.append;
    assign left_start   = out_reg.left_start;
    assign left_len     = out_reg.left_len;
    assign right_start  = out_reg.right_start;
    assign right_len    = out_reg.right_len;
    assign ok           = out_reg.ok;
    assign too_long     = out_reg.too_long;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("line position beyond line limit");

    a_gt_check_after_delim: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_gt_reg || app_reg) |-> delim_reg)
        else $error("append tracking without a delimiter");

    a_no_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (!ok && !append && left_len == '0 && right_len == '0))
        else $error("result fields set without a delimiter");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        line_end |=> (pos_reg == '0 && !delim_reg && !ovf_reg))
        else $error("line state not cleared after line end");

endmodule
